>>> src/bdenc_pkg.sv
// ============================================================================
// bdenc_pkg: shared types, constants and functions
// Checksum generator terms, alphabet lookup and the symbol queue word layout
// for the bech32 data-part encoder.
// ============================================================================
`default_nettype none

package bdenc_pkg;

    // Checksum width and symbol width
    localparam int CHK_W = 30;
    localparam int SYM_W = 5;

    // Checksum constants
    localparam logic [CHK_W-1:0] CHK_RESET = 30'd32;
    localparam logic [CHK_W-1:0] CHK_MASK  = 30'h3fffffff;

    // Generator terms, one per bit of the top symbol
    localparam logic [CHK_W-1:0] GEN_POLY [SYM_W] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    // Number of zero symbols folded in before the checksum goes out
    localparam int CHK_SYMS = 6;

    // Symbol queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One word in the symbol queue: a data symbol, fin set on the final one
    typedef struct packed {
        logic             fin;
        logic [SYM_W-1:0] sym;
    } sym_entry_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_DATA,
        ST_FINISH,
        ST_EMIT
    } back_state_t;

    // Fold one symbol into the checksum
    function automatic logic [CHK_W-1:0] fold_symbol(
        input logic [CHK_W-1:0] chk,
        input logic [SYM_W-1:0] sym
    );
        logic [SYM_W-1:0] top;
        logic [CHK_W-1:0] c;
        top = chk[CHK_W-1 -: SYM_W];
        c   = {chk[CHK_W-SYM_W-1:0], sym};
        for (int i = 0; i < SYM_W; i++) begin
            if (top[i]) begin
                c = c ^ GEN_POLY[i];
            end
        end
        return c;
    endfunction

    // Fold the trailing zero symbols and invert
    function automatic logic [CHK_W-1:0] close_checksum(input logic [CHK_W-1:0] chk);
        logic [CHK_W-1:0] c;
        c = chk;
        for (int i = 0; i < CHK_SYMS; i++) begin
            c = fold_symbol(c, '0);
        end
        return c ^ CHK_MASK;
    endfunction

    // Map a symbol to its alphabet character
    function automatic logic [6:0] sym_to_char(input logic [SYM_W-1:0] sym);
        logic [6:0] ch;
        unique case (sym)
            5'd0:  ch = 7'h71; // q
            5'd1:  ch = 7'h70; // p
            5'd2:  ch = 7'h7a; // z
            5'd3:  ch = 7'h72; // r
            5'd4:  ch = 7'h79; // y
            5'd5:  ch = 7'h39; // 9
            5'd6:  ch = 7'h78; // x
            5'd7:  ch = 7'h38; // 8
            5'd8:  ch = 7'h67; // g
            5'd9:  ch = 7'h66; // f
            5'd10: ch = 7'h32; // 2
            5'd11: ch = 7'h74; // t
            5'd12: ch = 7'h76; // v
            5'd13: ch = 7'h64; // d
            5'd14: ch = 7'h77; // w
            5'd15: ch = 7'h30; // 0
            5'd16: ch = 7'h73; // s
            5'd17: ch = 7'h33; // 3
            5'd18: ch = 7'h6a; // j
            5'd19: ch = 7'h6e; // n
            5'd20: ch = 7'h35; // 5
            5'd21: ch = 7'h34; // 4
            5'd22: ch = 7'h6b; // k
            5'd23: ch = 7'h68; // h
            5'd24: ch = 7'h63; // c
            5'd25: ch = 7'h65; // e
            5'd26: ch = 7'h36; // 6
            5'd27: ch = 7'h6d; // m
            5'd28: ch = 7'h75; // u
            5'd29: ch = 7'h61; // a
            5'd30: ch = 7'h37; // 7
            5'd31: ch = 7'h6c; // l
            default: ch = 7'h71;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> src/bech32_data_encoder_core.sv
// ============================================================================
// bech32_data_encoder_core: bech32 data-part encoder
// Streams message bytes in and the encoded characters plus checksum out.
// ============================================================================
// Usage:
//   The slave stream carries one message byte per word in s_tdata, with
//   s_tlast set on the final byte of a message. The master stream carries one
//   ASCII character per word in m_tdata[6:0]; m_tlast marks the sixth and
//   final checksum character of each message.
//   Each byte yields one or two 5-bit symbols; the final byte may add one
//   zero-padded symbol. The master side moves one character per cycle
//   while m_tready is high and symbols are queued, so the sustained input
//   rate is set by the single character output port. The first character
//   of a byte passes through the queue write, then the output register.
//   After the final symbol the checksum is closed in ST_FINISH; its six
//   characters follow one per cycle while m_tready is high. Meanwhile the
//   splitter keeps taking next-message bytes into the four-word queue.
//   A stalled m_tready holds the output word; the queue then fills and
//   s_tready drops. Synchronous reset (aresetn low) empties the queue, drops
//   m_tvalid and restarts the checksum for a new message.
// ============================================================================
`default_nettype none

module bech32_data_encoder_core
    import bdenc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] char_code, [7] zero
    output logic             m_tlast    // last_char
);

    logic       q_push, q_full, q_pop, q_empty;
    sym_entry_t q_wdata, q_rdata;

    // Split bytes into symbols
    bdenc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Buffer symbols between the two halves
    bdenc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // Fold checksum and drive characters
    bdenc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/bdenc_front.sv
// ============================================================================
// bdenc_front: byte intake and symbol splitter
// Accepts message bytes, regroups the bits into 5-bit symbols MSB first and
// pushes them into the symbol queue, adding the zero-padded tail symbol.
// ============================================================================
`default_nettype none

module bdenc_front
    import bdenc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_message
    input  wire logic        q_full,
    output logic             q_push,
    output sym_entry_t       q_wdata
);

    // Bit count reaches 4 + 8 = 12
    localparam logic [3:0] SYM_BITS = 4'(SYM_W);
    localparam logic [3:0] BYTE_BITS = 4'd8;

    logic [11:0] acc_reg;
    logic [3:0]  cnt_reg, cnt_next, cnt_after;
    logic        fin_reg, fin_next;
    logic        need_push, s_accept;
    logic [2:0]  shift_dn;
    logic [2:0]  shift_up;

    // Decide whether a symbol is ready and where it sits in the accumulator
    always_comb begin
        need_push = (cnt_reg >= SYM_BITS) || (fin_reg && (cnt_reg != '0));
        q_push    = need_push && !q_full;
        shift_dn  = 3'(cnt_reg - SYM_BITS);
        shift_up  = 3'(SYM_BITS - cnt_reg);

        if (cnt_reg >= SYM_BITS) begin
            q_wdata.sym = 5'(acc_reg >> shift_dn);
        end else begin
            q_wdata.sym = 5'(acc_reg << shift_up);
        end

        if (!q_push) begin
            cnt_after = cnt_reg;
        end else if (cnt_reg >= SYM_BITS) begin
            cnt_after = cnt_reg - SYM_BITS;
        end else begin
            cnt_after = '0;
        end

        q_wdata.fin = fin_reg && (cnt_after == '0);

        // Take a new word once no further symbol is owed
        s_tready = (cnt_after < SYM_BITS) && !(fin_reg && (cnt_after != '0));
        s_accept = s_tvalid && s_tready;

        if (s_accept) begin
            cnt_next = cnt_after + BYTE_BITS;
            fin_next = s_tlast;
        end else begin
            cnt_next = cnt_after;
            fin_next = fin_reg && (cnt_after != '0);
        end
    end

    // Hold the accumulator and bit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            fin_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            acc_reg <= {acc_reg[3:0], s_tdata};
        end
    end

endmodule

`default_nettype wire

>>> src/bdenc_queue.sv
// ============================================================================
// bdenc_queue: symbol queue
// Small FIFO that decouples the byte splitter from the checksum back end.
// ============================================================================
`default_nettype none

module bdenc_queue
    import bdenc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire sym_entry_t  wdata,
    output logic             full,
    input  wire logic        pop,
    output sym_entry_t       rdata,
    output logic             empty
);

    sym_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("symbol queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("symbol queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("symbol queue count out of range");

endmodule

`default_nettype wire

>>> src/bdenc_back.sv
// ============================================================================
// bdenc_back: checksum and character output
// Pops symbols, folds them into the checksum, drives the character register
// and appends the six checksum characters after the final symbol.
// ============================================================================
`default_nettype none

module bdenc_back
    import bdenc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire sym_entry_t  q_rdata,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] char_code, [7] zero
    output logic             m_tlast    // last_char
);

    localparam logic [2:0] EMIT_LAST = 3'(CHK_SYMS - 1);

    back_state_t        state_reg, state_next;
    logic [CHK_W-1:0]   chk_reg, chk_next;
    logic [CHK_W-1:0]   sr_reg, sr_next;
    logic [2:0]         emit_cnt_reg, emit_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [6:0]         m_char_reg, m_char_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    // Sequence data symbols, close the checksum, then emit it
    always_comb begin
        state_next    = state_reg;
        chk_next      = chk_reg;
        sr_next       = sr_reg;
        emit_cnt_next = emit_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_tlast_next  = m_tlast_reg;
        q_pop         = 1'b0;

        unique case (state_reg)
            ST_DATA: begin
                if (!q_empty && out_free) begin
                    q_pop         = 1'b1;
                    chk_next      = fold_symbol(chk_reg, q_rdata.sym);
                    m_tvalid_next = 1'b1;
                    m_char_next   = sym_to_char(q_rdata.sym);
                    m_tlast_next  = 1'b0;
                    if (q_rdata.fin) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                sr_next       = close_checksum(chk_reg);
                chk_next      = CHK_RESET;
                emit_cnt_next = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = sym_to_char(sr_reg[CHK_W-1 -: SYM_W]);
                    m_tlast_next  = (emit_cnt_reg == EMIT_LAST);
                    sr_next       = {sr_reg[CHK_W-SYM_W-1:0], {SYM_W{1'b0}}};
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    if (emit_cnt_reg == EMIT_LAST) begin
                        emit_cnt_next = '0;
                        state_next    = ST_DATA;
                    end
                end
            end
            default: begin
                state_next = ST_DATA;
            end
        endcase
    end

    // Hold sequencer state and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_DATA;
            chk_reg      <= CHK_RESET;
            emit_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chk_reg      <= chk_next;
            emit_cnt_reg <= emit_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg      <= sr_next;
        m_char_reg  <= m_char_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_chk_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> chk_reg == CHK_RESET)
        else $error("checksum not restarted after message");

    a_last_on_sixth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free && emit_cnt_reg == EMIT_LAST
        |=> state_reg == ST_DATA && m_tvalid_reg && m_tlast_reg)
        else $error("final checksum word not marked last");

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= EMIT_LAST)
        else $error("checksum word counter out of range");

    a_pop_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_DATA && out_free)
        else $error("symbol popped outside data phase");

endmodule

`default_nettype wire
